### hw/rtl/accelerating_key_autorepeat_unit_defines.svh
// Assertion macros for the checker of the key autorepeat unit.
// Depends on nothing; included by the checker file.
`ifndef ACCELERATING_KEY_AUTOREPEAT_UNIT_DEFINES_SVH
`define ACCELERATING_KEY_AUTOREPEAT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AKAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AKAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define AKAU_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/akau_pkg.sv
// Package of the accelerating key autorepeat unit: types, register codes,
// reset values and the interval shrink function. Depends on nothing.
`default_nettype none

package akau_pkg;

    localparam int KEY_COUNT_DEF = 32;
    localparam int MAX_KEYS      = 32;
    localparam int TIME_W        = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [TIME_W-1:0] MIN_DELAY_RST  = 32'd83;
    localparam logic [TIME_W-1:0] MAX_DELAY_RST  = 32'd500;
    localparam logic [TIME_W-1:0] DELAY_STEP_RST = 32'd83;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DELAY  = 2'd0,
        CFG_MAX_DELAY  = 2'd1,
        CFG_DELAY_STEP = 2'd2,
        CFG_GROUP_MODE = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_WALK,
        ST_DONE
    } t_state;

    // Interval after one repeat: drops by the step but never below the minimum.
    function automatic logic [TIME_W-1:0] shrink(input logic [TIME_W-1:0] iv,
                                                 input logic [TIME_W-1:0] min_d,
                                                 input logic [TIME_W-1:0] step);
        logic [TIME_W-1:0] res;
        if (iv > min_d && (iv - min_d) > step) begin
            res = iv - step;
        end else begin
            res = min_d;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/akau_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the per-key repeat state of the autorepeat unit.
`default_nettype none

module akau_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/accelerating_key_autorepeat_unit.sv
// Top level of the accelerating key autorepeat unit.
// Depends on akau_pkg and akau_ram.
`default_nettype none

// One input transfer is a frame: the held-key bitmap and a 32-bit timestamp. The unit returns
// one transfer per frame with the bitmap of key pulses. A new press pulses at once; a key held
// across frames pulses again when its interval has elapsed, and each repeat shortens that
// interval by delay_step down to min_delay. With group_mode set, one shared interval and
// timestamp govern all keys. Any configuration write re-arms every interval to max_delay and
// is meant to happen only while the unit is idle. A per-key frame walks the keys in ST_WALK
// and passes ST_DONE before the next possible accept, as the per-key intervals and timestamps
// live in one RAM that is read and written back one key per cycle. A group-mode frame passes
// through ST_GROUP and ST_DONE. The result sits in an output register, so a new frame is
// taken while it waits; a frame finishes only once that register is free.
module accelerating_key_autorepeat_unit #(
    parameter int KEY_COUNT = akau_pkg::KEY_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input frame.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] held_keys, [63:32] time_now
    // Result.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] pulse_keys
    // Configuration writes.
    input  wire logic        i_cfg_we,
    input  wire logic [akau_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int KEYS_USED = (KEY_COUNT < akau_pkg::MAX_KEYS) ? KEY_COUNT : akau_pkg::MAX_KEYS;
    localparam int IDX_W     = (KEYS_USED > 1) ? $clog2(KEYS_USED) : 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int TW        = akau_pkg::TIME_W;
    localparam logic [32:0] MASK_WIDE = (33'd1 << KEYS_USED) - 33'd1;
    localparam logic [31:0] KEY_MASK  = MASK_WIDE[31:0];
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(KEYS_USED);

    akau_pkg::t_state r_state, n_state;

    // Configuration.
    logic [TW-1:0] r_min_delay, n_min_delay;
    logic [TW-1:0] r_max_delay, n_max_delay;
    logic [TW-1:0] r_delay_step, n_delay_step;
    logic          r_group_mode, n_group_mode;

    // Frame state.
    logic [31:0]   r_prev, n_prev;
    logic          r_prev_any, n_prev_any;
    logic [TW-1:0] r_gint, n_gint;
    logic [TW-1:0] r_gstamp, n_gstamp;
    logic          r_g_ok, n_g_ok;
    logic [KEYS_USED-1:0] r_iv_ok, n_iv_ok;
    logic [KEYS_USED-1:0] r_st_ok, n_st_ok;
    logic [CNT_W-1:0]     r_idx, n_idx;

    // Payload.
    logic [31:0]   r_held, n_held;
    logic [TW-1:0] r_now, n_now;
    logic [31:0]   r_pulse, n_pulse;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_data, n_out_data;

    // RAM ports: entry is {interval, stamp}.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [2*TW-1:0]   ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [2*TW-1:0]   ram_rdata;

    // Per-key and group evaluation.
    logic [IDX_W-1:0]  key_idx;
    logic [CNT_W-1:0]  key_cnt;
    logic [TW-1:0]     key_iv;
    logic [TW-1:0]     key_stamp;
    logic              key_due;
    logic [TW-1:0]     grp_iv;
    logic              grp_any;
    logic              grp_due;

    akau_ram #(
        .WIDTH (2 * TW),
        .DEPTH (KEYS_USED)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = r_idx[IDX_W-1:0];
    assign key_cnt   = r_idx - CNT_W'(1);
    assign key_idx   = key_cnt[IDX_W-1:0];

    // Re-armed or unwritten entries read max_delay; only unwritten ones read a zero stamp.
    assign key_iv    = r_iv_ok[key_idx] ? ram_rdata[2*TW-1:TW] : r_max_delay;
    assign key_stamp = r_st_ok[key_idx] ? ram_rdata[TW-1:0] : '0;
    assign key_due   = (r_now - key_stamp) >= key_iv;

    assign grp_iv  = r_g_ok ? r_gint : r_max_delay;
    assign grp_any = |r_held;
    assign grp_due = (r_now - r_gstamp) >= grp_iv;

    assign s_tready = (r_state == akau_pkg::ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_min_delay  = r_min_delay;
        n_max_delay  = r_max_delay;
        n_delay_step = r_delay_step;
        n_group_mode = r_group_mode;
        n_prev       = r_prev;
        n_prev_any   = r_prev_any;
        n_gint       = r_gint;
        n_gstamp     = r_gstamp;
        n_g_ok       = r_g_ok;
        n_iv_ok      = r_iv_ok;
        n_st_ok      = r_st_ok;
        n_idx        = r_idx;
        n_held       = r_held;
        n_now        = r_now;
        n_pulse      = r_pulse;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_waddr    = key_idx;
        ram_wdata    = {key_iv, key_stamp};

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            akau_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_held  = s_tdata[31:0] & KEY_MASK;
                    n_now   = s_tdata[63:32];
                    n_pulse = '0;
                    n_idx   = '0;
                    n_state = r_group_mode ? akau_pkg::ST_GROUP : akau_pkg::ST_WALK;
                end
            end
            akau_pkg::ST_GROUP: begin
                if (r_prev_any && grp_any) begin
                    if (grp_due) begin
                        n_pulse  = r_held;
                        n_gint   = akau_pkg::shrink(grp_iv, r_min_delay, r_delay_step);
                        n_gstamp = r_now;
                        n_g_ok   = 1'b1;
                    end
                end else begin
                    n_pulse  = r_held;
                    n_gint   = r_max_delay;
                    n_gstamp = r_now;
                    n_g_ok   = 1'b1;
                end
                n_prev_any = grp_any;
                n_state    = akau_pkg::ST_DONE;
            end
            akau_pkg::ST_WALK: begin
                // The read for key r_idx goes out while key r_idx - 1 is updated.
                if (r_idx != '0) begin
                    if (r_held[key_idx] && r_prev[key_idx]) begin
                        if (key_due) begin
                            n_pulse[key_idx] = 1'b1;
                            ram_we    = 1'b1;
                            ram_wdata = {akau_pkg::shrink(key_iv, r_min_delay, r_delay_step),
                                         r_now};
                        end
                    end else begin
                        n_pulse[key_idx] = r_held[key_idx];
                        ram_we    = 1'b1;
                        ram_wdata = {r_max_delay, r_now};
                    end
                    if (ram_we) begin
                        n_iv_ok[key_idx] = 1'b1;
                        n_st_ok[key_idx] = 1'b1;
                    end
                end
                n_idx = r_idx + CNT_W'(1);
                if (r_idx == LAST_CNT) begin
                    n_state = akau_pkg::ST_DONE;
                end
            end
            akau_pkg::ST_DONE: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_pulse;
                    n_prev      = r_held;
                    n_state     = akau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = akau_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (akau_pkg::t_cfg_reg'(i_cfg_idx))
                akau_pkg::CFG_MIN_DELAY:  n_min_delay  = i_cfg_data;
                akau_pkg::CFG_MAX_DELAY:  n_max_delay  = i_cfg_data;
                akau_pkg::CFG_DELAY_STEP: n_delay_step = i_cfg_data;
                akau_pkg::CFG_GROUP_MODE: n_group_mode = i_cfg_data[0];
                default:                  n_group_mode = r_group_mode;
            endcase
            // Re-arm every interval; stamps and held history stay.
            n_iv_ok = '0;
            n_g_ok  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= akau_pkg::ST_IDLE;
            r_min_delay  <= akau_pkg::MIN_DELAY_RST;
            r_max_delay  <= akau_pkg::MAX_DELAY_RST;
            r_delay_step <= akau_pkg::DELAY_STEP_RST;
            r_group_mode <= 1'b0;
            r_prev       <= '0;
            r_prev_any   <= 1'b0;
            r_gstamp     <= '0;
            r_g_ok       <= 1'b0;
            r_iv_ok      <= '0;
            r_st_ok      <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_min_delay  <= n_min_delay;
            r_max_delay  <= n_max_delay;
            r_delay_step <= n_delay_step;
            r_group_mode <= n_group_mode;
            r_prev       <= n_prev;
            r_prev_any   <= n_prev_any;
            r_gstamp     <= n_gstamp;
            r_g_ok       <= n_g_ok;
            r_iv_ok      <= n_iv_ok;
            r_st_ok      <= n_st_ok;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gint     <= n_gint;
        r_held     <= n_held;
        r_now      <= n_now;
        r_pulse    <= n_pulse;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

### hw/rtl/akau_checker.sv
// Port-level checker for the accelerating key autorepeat unit, bound to its top level.
// Depends on the assertion macros in accelerating_key_autorepeat_unit_defines.svh.
`default_nettype none

`include "accelerating_key_autorepeat_unit_defines.svh"

module akau_checker #(
    parameter int KEY_COUNT = akau_pkg::KEY_COUNT_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    localparam int KEYS_USED = (KEY_COUNT < akau_pkg::MAX_KEYS) ? KEY_COUNT : akau_pkg::MAX_KEYS;
    localparam logic [32:0] MASK_WIDE = (33'd1 << KEYS_USED) - 33'd1;
    localparam logic [31:0] KEY_MASK  = MASK_WIDE[31:0];

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready;

    `AKAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `AKAU_ASSERT_NOW(a_no_ghost_keys, i_clk, i_rst_n, m_tvalid, (m_tdata & ~KEY_MASK) == 32'd0, "pulse on a key beyond the key count")
    `AKAU_ASSERT_NEXT(a_one_frame, i_clk, i_rst_n, in_xfer, !s_tready, "second frame taken while one is in work")
    `AKAU_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_tvalid && s_tready, "result or busy state survived reset")

endmodule

bind accelerating_key_autorepeat_unit akau_checker #(
    .KEY_COUNT (KEY_COUNT)
) u_akau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
);

`default_nettype wire

### verif/tb_accelerating_key_autorepeat_unit.sv
// Self-checking testbench for the accelerating key autorepeat unit: frames go in on the
// slave stream, pulse bitmaps are predicted here and compared on the master stream.
// Depends on akau_pkg and the RTL of accelerating_key_autorepeat_unit.
`default_nettype none

module tb_accelerating_key_autorepeat_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS = akau_pkg::KEY_COUNT_DEF;
    // A per-key frame walks every key before the next accept; even with long random stalls on
    // both sides a transfer happens well before the watchdog limit below runs out.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = KEYS + 3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;     // [31:0] held_keys, [63:32] time_now
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;     // [31:0] pulse_keys
    logic                 i_cfg_we;
    logic [akau_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;

    // Mirror of the registers and timer state.
    logic [31:0] cfg_min;
    logic [31:0] cfg_max;
    logic [31:0] cfg_step;
    logic        cfg_group;
    logic [31:0] held_last;
    logic [31:0] key_iv [KEYS];
    logic [31:0] key_time [KEYS];
    logic [31:0] grp_iv;
    logic [31:0] grp_time;
    logic        any_last;

    logic [31:0] pulses_due [$];
    logic [31:0] due_pulse;

    int unsigned send_gap_pct;
    int unsigned stall_pct;
    int unsigned errors;
    int unsigned frames_sent;
    int unsigned results_seen;
    int unsigned setting_changes;

    accelerating_key_autorepeat_unit #(
        .KEY_COUNT(KEYS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void rearm_intervals();
        int k;
        for (k = 0; k < KEYS; k++) begin
            key_iv[k] = cfg_max;
        end
        grp_iv = cfg_max;
    endfunction

    function automatic void reset_timers();
        int k;
        cfg_min   = akau_pkg::MIN_DELAY_RST;
        cfg_max   = akau_pkg::MAX_DELAY_RST;
        cfg_step  = akau_pkg::DELAY_STEP_RST;
        cfg_group = 1'b0;
        held_last = '0;
        for (k = 0; k < KEYS; k++) begin
            key_time[k] = '0;
        end
        grp_time = '0;
        any_last = 1'b0;
        rearm_intervals();
    endfunction

    // Interval after a repeat; an interval already under the minimum climbs to it.
    function automatic logic [31:0] next_interval(input logic [31:0] iv);
        logic [31:0] res;
        res = cfg_min;
        if (iv > cfg_min && (iv - cfg_min) > cfg_step) begin
            res = iv - cfg_step;
        end
        return res;
    endfunction

    function automatic logic [31:0] predict_pulses(input logic [31:0] held,
                                                   input logic [31:0] now);
        logic [31:0] pulse;
        logic [31:0] elapsed;
        logic        any;
        int          k;
        pulse = '0;
        if (cfg_group) begin
            any     = |held;
            elapsed = now - grp_time;
            if (any_last && any) begin
                if (elapsed >= grp_iv) begin
                    pulse    = held;
                    grp_iv   = next_interval(grp_iv);
                    grp_time = now;
                end
            end else begin
                pulse    = held;
                grp_time = now;
                grp_iv   = cfg_max;
            end
            any_last = any;
        end else begin
            for (k = 0; k < KEYS; k++) begin
                if (held[k] && held_last[k]) begin
                    elapsed = now - key_time[k];
                    if (elapsed >= key_iv[k]) begin
                        pulse[k]    = 1'b1;
                        key_iv[k]   = next_interval(key_iv[k]);
                        key_time[k] = now;
                    end
                end else begin
                    pulse[k]    = held[k];
                    key_time[k] = now;
                    key_iv[k]   = cfg_max;
                end
            end
        end
        held_last = held;
        return pulse;
    endfunction

    // Called at a rising edge; returns at the edge where the frame was taken.
    task automatic send_frame(input logic [31:0] held, input logic [31:0] now);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, held};
        do @(posedge i_clk); while (!s_tready);
        pulses_due.push_back(predict_pulses(held, now));
        frames_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pulses_due.size() != 0);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drops the write enable after each write and waits before returning, so back-to-back writes never collide.
    task automatic write_reg(input akau_pkg::t_cfg_reg idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            akau_pkg::CFG_MIN_DELAY:  cfg_min   = value;
            akau_pkg::CFG_MAX_DELAY:  cfg_max   = value;
            akau_pkg::CFG_DELAY_STEP: cfg_step  = value;
            akau_pkg::CFG_GROUP_MODE: cfg_group = value[0];
            default:                  cfg_group = cfg_group;
        endcase
        rearm_intervals();
        @(posedge i_clk);
    endtask

    // Checker: every transfer on the master side must match the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pulses_due.size() == 0) begin
                    $error("pulse_keys: no frame pending, got %h", m_tdata);
                    errors++;
                end else begin
                    due_pulse = pulses_due.pop_front();
                    if (m_tdata !== due_pulse) begin
                        $error("pulse_keys: expected %h, actual %h", due_pulse, m_tdata);
                        errors++;
                    end
                    results_seen++;
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_accelerating_key_autorepeat_unit: errors");
        $finish;
    end

    // Reset values: fresh presses, repeats below and at the interval, timestamp wrap.
    task automatic test_fresh_press();
        send_frame(32'h0000_0000, 32'd0);
        send_frame(32'h0000_0001, 32'd10);
        send_frame(32'h0000_0001, 32'd100);
        send_frame(32'h0000_0001, 32'd510);
        send_frame(32'hFFFF_FFFF, 32'd600);
        send_frame(32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_frame(32'h8000_0000, 32'd5);
        send_frame(32'h0000_0000, 32'd5);
    endtask

    // Zero and full-scale intervals, saturation at the minimum, and re-arm on a write.
    task automatic test_interval_limits();
        quiesce();
        write_reg(akau_pkg::CFG_MIN_DELAY, 32'd0);
        write_reg(akau_pkg::CFG_MAX_DELAY, 32'd0);
        write_reg(akau_pkg::CFG_DELAY_STEP, 32'd0);
        send_frame(32'h0000_0005, 32'd7);
        send_frame(32'h0000_0005, 32'd7);
        quiesce();
        write_reg(akau_pkg::CFG_MAX_DELAY, 32'hFFFF_FFFF);
        write_reg(akau_pkg::CFG_DELAY_STEP, 32'hFFFF_FFFF);
        write_reg(akau_pkg::CFG_MIN_DELAY, 32'd1);
        send_frame(32'h0000_0003, 32'd0);
        send_frame(32'h0000_0003, 32'hFFFF_FFFF);
        quiesce();
        write_reg(akau_pkg::CFG_MIN_DELAY, 32'hFFFF_FFFF);
        send_frame(32'h0000_0002, 32'hFFFF_FFFE);
        quiesce();
        // Maximum below minimum: the first repeat lifts the interval up to the minimum.
        write_reg(akau_pkg::CFG_MIN_DELAY, 32'd100);
        write_reg(akau_pkg::CFG_MAX_DELAY, 32'd10);
        write_reg(akau_pkg::CFG_DELAY_STEP, 32'd3);
        send_frame(32'h0000_0004, 32'd0);
        send_frame(32'h0000_0004, 32'd10);
        send_frame(32'h0000_0004, 32'd50);
        send_frame(32'h0000_0004, 32'd110);
    endtask

    // One shared timer for all keys, then back to per-key timing via a write with junk bits.
    task automatic test_group_timer();
        quiesce();
        write_reg(akau_pkg::CFG_MIN_DELAY, akau_pkg::MIN_DELAY_RST);
        write_reg(akau_pkg::CFG_MAX_DELAY, akau_pkg::MAX_DELAY_RST);
        write_reg(akau_pkg::CFG_DELAY_STEP, akau_pkg::DELAY_STEP_RST);
        write_reg(akau_pkg::CFG_GROUP_MODE, 32'h0000_0001);
        send_frame(32'h0000_0000, 32'd1000);
        send_frame(32'h0000_0001, 32'd1000);
        send_frame(32'h0000_0006, 32'd1200);
        send_frame(32'h0000_0006, 32'd1500);
        send_frame(32'hFFFF_FFFF, 32'd1600);
        send_frame(32'h0000_0000, 32'd1700);
        send_frame(32'h8000_0000, 32'd1701);
        quiesce();
        write_reg(akau_pkg::CFG_GROUP_MODE, 32'hFFFF_FFFE);
        send_frame(32'h8000_0000, 32'd1702);
    endtask

    function automatic logic [31:0] pick_delay();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            return $urandom_range(0, 300);
        end else if (sel < 80) begin
            return 32'd0;
        end else if (sel < 90) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    task automatic pick_settings();
        logic [31:0] grp_word;
        grp_word = ($urandom & 32'hFFFF_FFFE) | ($urandom_range(1) ? 32'd1 : 32'd0);
        write_reg(akau_pkg::CFG_MIN_DELAY, pick_delay());
        write_reg(akau_pkg::CFG_MAX_DELAY, pick_delay() + ($urandom_range(1) ? 32'd400 : 32'd0));
        write_reg(akau_pkg::CFG_DELAY_STEP, pick_delay());
        write_reg(akau_pkg::CFG_GROUP_MODE, grp_word);
        setting_changes++;
    endtask

    // Mostly the same keys held from frame to frame, so repeats and acceleration happen.
    function automatic logic [31:0] next_held(input logic [31:0] cur);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55) begin
            return cur;
        end else if (sel < 70) begin
            return cur ^ (32'h1 << $urandom_range(31));
        end else if (sel < 82) begin
            return $urandom & $urandom & $urandom;
        end else if (sel < 88) begin
            return 32'h0;
        end else if (sel < 93) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // Time steps cluster around the configured intervals so both sides of each compare occur.
    function automatic logic [31:0] next_delta();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            return 32'd0;
        end else if (sel < 45) begin
            return $urandom_range(0, 150);
        end else if (sel < 70) begin
            return $urandom_range(0, 700);
        end else if (sel < 80) begin
            return cfg_min + $urandom_range(0, 2) - 32'd1;
        end else if (sel < 90) begin
            return cfg_max + $urandom_range(0, 2) - 32'd1;
        end
        return $urandom;
    endfunction

    task automatic test_random_phases();
        int          phase;
        int          n;
        logic [31:0] held;
        logic [31:0] now;
        held = '0;
        now  = $urandom;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 64; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 64; end
                default: begin send_gap_pct = 28; stall_pct = 28; end
            endcase
            for (n = 0; n < 150; n++) begin
                if (n % 50 == 0) begin
                    quiesce();
                    pick_settings();
                end else if ($urandom_range(99) < 2) begin
                    // Let the unit run completely dry before the next frame.
                    drain_results();
                end
                held = next_held(held);
                now  = now + next_delta();
                send_frame(held, now);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = akau_pkg::CFG_MIN_DELAY;
        i_cfg_data      = '0;
        send_gap_pct    = 0;
        stall_pct       = 0;
        errors          = 0;
        frames_sent     = 0;
        results_seen    = 0;
        setting_changes = 0;
        reset_timers();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fresh_press();
        test_interval_limits();
        test_group_timer();
        test_random_phases();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pulses_due.size() != 0) begin
            $error("pulse_keys: %0d frames never answered", pulses_due.size());
            errors++;
        end
        $display("Checked %0d pulse bitmaps for %0d frames over %0d random register settings,",
                 results_seen, frames_sent, setting_changes);
        $display("per-key and shared timers, interval extremes, and four stall patterns.");
        if (errors == 0) begin
            $display("tb_accelerating_key_autorepeat_unit: clean");
        end else begin
            $display("tb_accelerating_key_autorepeat_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/akau_pkg.sv
hw/rtl/akau_ram.sv
hw/rtl/accelerating_key_autorepeat_unit.sv
hw/rtl/akau_checker.sv
verif/tb_accelerating_key_autorepeat_unit.sv
